FILE: sv/mppt_pkg.sv
package mppt_pkg;

    localparam int COORD_BITS_DEFAULT = 12;

    localparam int RX_BITS     = 8;
    localparam int POS_BITS    = 12;
    localparam int BUTTON_BITS = 3;
    localparam int CFG_BITS    = 12;
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = 32;

    localparam logic [RX_BITS-1:0] HDR_OVERFLOW = 8'hC0;
    localparam logic [RX_BITS-1:0] HDR_BUTTONS  = 8'h07;
    localparam logic [RX_BITS-1:0] HDR_XSIGN    = 8'h10;
    localparam logic [RX_BITS-1:0] HDR_YSIGN    = 8'h20;

    localparam logic [CFG_BITS-1:0] MAX_X_RESET = 12'd640;
    localparam logic [CFG_BITS-1:0] MAX_Y_RESET = 12'd200;

    typedef enum logic {
        REG_MAX_X = 1'b0,
        REG_MAX_Y = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        SLOT_HEADER = 3'b001,
        SLOT_XDELTA = 3'b010,
        SLOT_YDELTA = 3'b100
    } slot_t;

endpackage

FILE: sv/mouse_packet_position_tracker.sv
// Mouse packet position tracker. Accepts one received byte per s_ transaction and
// returns one result per byte: the current clamped position, the button bits and
// tlast set when the byte completed a three-byte packet (header, X delta, Y delta).
// A header with either overflow bit set is dropped and the block keeps waiting for
// a header. X moves by the 9-bit signed delta, Y moves opposite to its delta, and
// each coordinate is clamped to 0..max, with max_x (index 0, reset 640) and max_y
// (index 1, reset 200) written over the cfg_ channel, by the user only while the
// block is idle (the block does not enforce it). Throughput is one byte per cycle:
// the packet update is a single add and clamp per coordinate into the output register,
// and a new byte is taken whenever that register is empty or being read in the same cycle.
module mouse_packet_position_tracker
    import mppt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // [7:0] rx_byte

    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,   // [11:0] pos_x, [23:12] pos_y,
                                                 // [26:24] button_bits, [31:27] zero
    output logic                      m_tlast,   // packet_done

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data
);

    localparam int SW = COORD_BITS + 2;

    slot_t                   slot_reg, slot_next;
    logic [RX_BITS-1:0]      header_reg, header_next;
    logic [RX_BITS-1:0]      xbyte_reg, xbyte_next;
    logic [COORD_BITS-1:0]   cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]   cur_y_reg, cur_y_next;
    logic [BUTTON_BITS-1:0]  buttons_reg, buttons_next;
    logic [COORD_BITS-1:0]   max_x_reg, max_y_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [POS_BITS-1:0]     out_x_reg, out_y_reg;
    logic [BUTTON_BITS-1:0]  out_buttons_reg;
    logic                    out_done_reg, done;

    logic                    accept;
    logic [RX_BITS-1:0]      rx_byte;
    logic signed [SW-1:0]    dx, dy, sum_x, sum_y;
    logic [COORD_BITS-1:0]   clamp_x, clamp_y;

    assign rx_byte   = s_tdata[RX_BITS-1:0];
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign dx    = {{(SW-9){|(header_reg & HDR_XSIGN)}}, |(header_reg & HDR_XSIGN), xbyte_reg};
    assign dy    = {{(SW-9){|(header_reg & HDR_YSIGN)}}, |(header_reg & HDR_YSIGN), rx_byte};
    assign sum_x = $signed({2'b00, cur_x_reg}) + dx;
    assign sum_y = $signed({2'b00, cur_y_reg}) - dy;

    always_comb begin
        if (sum_x[SW-1]) begin
            clamp_x = '0;
        end else if (sum_x > $signed({2'b00, max_x_reg})) begin
            clamp_x = max_x_reg;
        end else begin
            clamp_x = sum_x[COORD_BITS-1:0];
        end
        if (sum_y[SW-1]) begin
            clamp_y = '0;
        end else if (sum_y > $signed({2'b00, max_y_reg})) begin
            clamp_y = max_y_reg;
        end else begin
            clamp_y = sum_y[COORD_BITS-1:0];
        end
    end

    always_comb begin
        slot_next    = slot_reg;
        header_next  = header_reg;
        xbyte_next   = xbyte_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        buttons_next = buttons_reg;
        done         = 1'b0;
        case (slot_reg)
            SLOT_HEADER: begin
                if ((rx_byte & HDR_OVERFLOW) == '0) begin
                    header_next = rx_byte;
                    slot_next   = SLOT_XDELTA;
                end
            end
            SLOT_XDELTA: begin
                xbyte_next = rx_byte;
                slot_next  = SLOT_YDELTA;
            end
            default: begin
                buttons_next = header_reg[BUTTON_BITS-1:0];
                cur_x_next   = clamp_x;
                cur_y_next   = clamp_y;
                slot_next    = SLOT_HEADER;
                done         = 1'b1;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg      <= SLOT_HEADER;
            header_reg    <= '0;
            xbyte_reg     <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            buttons_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                slot_reg    <= slot_next;
                header_reg  <= header_next;
                xbyte_reg   <= xbyte_next;
                cur_x_reg   <= cur_x_next;
                cur_y_reg   <= cur_y_next;
                buttons_reg <= buttons_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_x_reg <= COORD_BITS'(MAX_X_RESET);
            max_y_reg <= COORD_BITS'(MAX_Y_RESET);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                REG_MAX_X: max_x_reg <= COORD_BITS'(cfg_data);
                REG_MAX_Y: max_y_reg <= COORD_BITS'(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_x_reg       <= POS_BITS'(cur_x_next);
            out_y_reg       <= POS_BITS'(cur_y_next);
            out_buttons_reg <= buttons_next;
            out_done_reg    <= done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_BITS'({out_buttons_reg, out_y_reg, out_x_reg});
    assign m_tlast  = out_done_reg;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mppt_pkg::*;

    localparam int SETTLE_CYCLES   = 4;
    localparam int LONG_HOLD       = 300;
    localparam int PHASES          = 7;
    localparam int BYTES_PER_PHASE = 100;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int DIRECTED_ROWS   = 23;
    localparam int MAX_REPORTS     = 20;

    typedef enum logic {
        ROW_BYTE,
        ROW_LIMITS
    } row_kind_t;

    typedef struct packed {
        logic [POS_BITS-1:0]    pos_x;
        logic [POS_BITS-1:0]    pos_y;
        logic [BUTTON_BITS-1:0] buttons;
        logic                   done;
    } position_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [RX_BITS-1:0]  rx;
        logic                fixed;
        position_t           want;
        logic [CFG_BITS-1:0] lim_x;
        logic [CFG_BITS-1:0] lim_y;
    } stim_row_t;

    localparam position_t NO_WANT = '0;

    localparam stim_row_t STIM_ROWS [DIRECTED_ROWS] = '{
        '{ROW_BYTE,   8'hC0, 1'b1, '{12'd0,   12'd0,   3'd0, 1'b0}, '0, '0},
        '{ROW_BYTE,   8'h40, 1'b1, '{12'd0,   12'd0,   3'd0, 1'b0}, '0, '0},
        '{ROW_BYTE,   8'h80, 1'b1, '{12'd0,   12'd0,   3'd0, 1'b0}, '0, '0},
        '{ROW_BYTE,   8'h0F, 1'b1, '{12'd0,   12'd0,   3'd0, 1'b0}, '0, '0},
        '{ROW_BYTE,   8'hFF, 1'b1, '{12'd0,   12'd0,   3'd0, 1'b0}, '0, '0},
        '{ROW_BYTE,   8'h00, 1'b1, '{12'd255, 12'd0,   3'd7, 1'b1}, '0, '0},
        '{ROW_BYTE,   8'h10, 1'b1, '{12'd255, 12'd0,   3'd7, 1'b0}, '0, '0},
        '{ROW_BYTE,   8'h00, 1'b1, '{12'd255, 12'd0,   3'd7, 1'b0}, '0, '0},
        '{ROW_BYTE,   8'h80, 1'b1, '{12'd0,   12'd0,   3'd0, 1'b1}, '0, '0},
        '{ROW_BYTE,   8'h20, 1'b1, '{12'd0,   12'd0,   3'd0, 1'b0}, '0, '0},
        '{ROW_BYTE,   8'hFF, 1'b1, '{12'd0,   12'd0,   3'd0, 1'b0}, '0, '0},
        '{ROW_BYTE,   8'h00, 1'b1, '{12'd255, 12'd200, 3'd0, 1'b1}, '0, '0},
        '{ROW_LIMITS, 8'h00, 1'b0, NO_WANT, 12'd640, 12'd100},
        '{ROW_BYTE,   8'h01, 1'b0, NO_WANT, '0, '0},
        '{ROW_BYTE,   8'h00, 1'b0, NO_WANT, '0, '0},
        '{ROW_BYTE,   8'h00, 1'b0, NO_WANT, '0, '0},
        '{ROW_LIMITS, 8'h00, 1'b0, NO_WANT, 12'd4095, 12'd4095},
        '{ROW_BYTE,   8'h3A, 1'b0, NO_WANT, '0, '0},
        '{ROW_BYTE,   8'h01, 1'b0, NO_WANT, '0, '0},
        '{ROW_BYTE,   8'hFF, 1'b0, NO_WANT, '0, '0},
        '{ROW_BYTE,   8'h0C, 1'b0, NO_WANT, '0, '0},
        '{ROW_BYTE,   8'hC0, 1'b0, NO_WANT, '0, '0},
        '{ROW_BYTE,   8'hC0, 1'b0, NO_WANT, '0, '0}
    };

    logic                      aclk;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic                      m_tlast;
    logic                      cfg_valid;
    logic                      cfg_ready;
    cfg_index_t                cfg_index;
    logic [CFG_BITS-1:0]       cfg_data;

    mouse_packet_position_tracker u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    slot_t                  trk_slot    = SLOT_HEADER;
    logic [RX_BITS-1:0]     trk_hdr     = '0;
    logic [RX_BITS-1:0]     trk_xbyte   = '0;
    logic [POS_BITS-1:0]    trk_x       = '0;
    logic [POS_BITS-1:0]    trk_y       = '0;
    logic [BUTTON_BITS-1:0] trk_buttons = '0;
    logic [CFG_BITS-1:0]    lim_x       = MAX_X_RESET;
    logic [CFG_BITS-1:0]    lim_y       = MAX_Y_RESET;

    position_t pending_positions [$];

    int  errors        = 0;
    int  cycles        = 0;
    int  bytes_taken   = 0;
    int  bytes_dropped = 0;
    int  packets       = 0;
    int  settings      = 0;
    bit  idling        = 1'b1;
    bit  hold_off_request = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [POS_BITS-1:0] clamp_to(int v, logic [CFG_BITS-1:0] hi);
        if (v < 0) return '0;
        if (v > int'(hi)) return hi;
        return POS_BITS'(v);
    endfunction

    task automatic track_byte(input logic [RX_BITS-1:0] rx, output position_t res,
                              output bit dropped);
        int nx;
        int ny;
        dropped  = 1'b0;
        res.done = 1'b0;
        case (trk_slot)
            SLOT_HEADER: begin
                if ((rx & HDR_OVERFLOW) == '0) begin
                    trk_hdr  = rx;
                    trk_slot = SLOT_XDELTA;
                end else begin
                    dropped = 1'b1;
                end
            end
            SLOT_XDELTA: begin
                trk_xbyte = rx;
                trk_slot  = SLOT_YDELTA;
            end
            default: begin
                nx = int'(trk_x) + int'($signed({(trk_hdr & HDR_XSIGN) != '0, trk_xbyte}));
                ny = int'(trk_y) - int'($signed({(trk_hdr & HDR_YSIGN) != '0, rx}));
                trk_buttons = BUTTON_BITS'(trk_hdr & HDR_BUTTONS);
                trk_x       = clamp_to(nx, lim_x);
                trk_y       = clamp_to(ny, lim_y);
                trk_slot    = SLOT_HEADER;
                res.done    = 1'b1;
                packets++;
            end
        endcase
        res.pos_x   = trk_x;
        res.pos_y   = trk_y;
        res.buttons = trk_buttons;
    endtask

    task automatic send_byte(input logic [RX_BITS-1:0] rx, input logic fixed,
                             input position_t want);
        position_t calc;
        bit        dropped;
        if (idling && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
        track_byte(rx, calc, dropped);
        pending_positions.push_back(fixed ? want : calc);
        if (dropped) bytes_dropped++;
        else bytes_taken++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_positions.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limits(input logic [CFG_BITS-1:0] lx, input logic [CFG_BITS-1:0] ly);
        cfg_index_t which;
        which = cfg_index_t'($urandom_range(0, 1));
        repeat (2) begin
            cfg_valid <= 1'b1;
            cfg_index <= which;
            cfg_data  <= (which == REG_MAX_X) ? lx : ly;
            do @(posedge aclk); while (!cfg_ready);
            if (which == REG_MAX_X) lim_x = lx;
            else lim_y = ly;
            @(negedge aclk);
            which = (which == REG_MAX_X) ? REG_MAX_Y : REG_MAX_X;
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (idling && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        position_t got;
        position_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.pos_x   = m_tdata[POS_BITS-1:0];
            got.pos_y   = m_tdata[2*POS_BITS-1:POS_BITS];
            got.buttons = m_tdata[2*POS_BITS+BUTTON_BITS-1:2*POS_BITS];
            got.done    = m_tlast;
            if (pending_positions.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected transaction x=%0d y=%0d buttons=%0d done=%0d",
                             $time, got.pos_x, got.pos_y, got.buttons, got.done);
            end else begin
                want = pending_positions.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display({"%0t: expected x=%0d y=%0d buttons=%0d done=%0d,",
                                  " actual x=%0d y=%0d buttons=%0d done=%0d"},
                                 $time, want.pos_x, want.pos_y, want.buttons, want.done,
                                 got.pos_x, got.pos_y, got.buttons, got.done);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int                  i;
        int                  ph;
        int                  target;
        int                  kind;
        bit                  paused;
        logic [CFG_BITS-1:0] lx;
        logic [CFG_BITS-1:0] ly;
        logic [RX_BITS-1:0]  hdr;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MAX_X;
        cfg_data  = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (i = 0; i < DIRECTED_ROWS; i++) begin
            if (STIM_ROWS[i].kind == ROW_LIMITS) begin
                drain_results();
                write_limits(STIM_ROWS[i].lim_x, STIM_ROWS[i].lim_y);
            end else begin
                send_byte(STIM_ROWS[i].rx, STIM_ROWS[i].fixed, STIM_ROWS[i].want);
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            drain_results();
            case (ph)
                0: begin
                    lx = '0;
                    ly = '0;
                end
                1: begin
                    lx = '1;
                    ly = '1;
                end
                2: begin
                    lx = 12'd1;
                    ly = 12'd1;
                end
                3: begin
                    lx = MAX_X_RESET;
                    ly = MAX_Y_RESET;
                end
                default: begin
                    lx = CFG_BITS'($urandom_range(0, 4095));
                    ly = CFG_BITS'($urandom_range(0, 4095));
                end
            endcase
            write_limits(lx, ly);
            idling = (ph != PHASES - 1);
            if (ph == 1) hold_off_request = 1'b1;
            paused = 1'b0;
            target = bytes_taken + BYTES_PER_PHASE;
            while (bytes_taken < target) begin
                if (ph == 3 && !paused && bytes_taken >= target - BYTES_PER_PHASE / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
                kind = $urandom_range(0, 9);
                hdr  = RX_BITS'($urandom_range(0, 255)) & ~HDR_OVERFLOW;
                if (kind == 0) begin
                    send_byte(RX_BITS'($urandom_range(0, 255)), 1'b0, NO_WANT);
                end else begin
                    send_byte(hdr, 1'b0, NO_WANT);
                    send_byte(RX_BITS'($urandom_range(0, 255)), 1'b0, NO_WANT);
                    if (kind != 1) send_byte(RX_BITS'($urandom_range(0, 255)), 1'b0, NO_WANT);
                end
            end
        end
        drain_results();

        $display("Covered %0d tracked bytes and %0d dropped overflow headers,",
                 bytes_taken, bytes_dropped);
        $display("%0d completed packets under %0d clamp-limit settings, with stalls on both sides",
                 packets, settings);
        if (errors == 0 && pending_positions.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
